### hw/rtl/hpq_pkg.sv
// Shared types, sizes and codes for the binary max-heap priority queue.
package hpq_pkg;

  // Heap size and the widths that follow from it
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 8;
  localparam int STAT_W   = 2;

  // Operation codes on the mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // One heap entry
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Request from the sequencer to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_RESP
  } state_t;

endpackage

### hw/rtl/binary_max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue: sequencer, count and result register.
//
// Input channel (in_valid / in_ready) takes one word per operation: mode 0
// enqueues {item_data, item_priority}, mode 1 dequeues the entry of largest
// priority. Output channel (out_valid / out_ready) returns exactly one word
// per operation: out_data (dequeued data, else zero), status and occupancy.
// Equal priorities keep the order of a classic array heap: sift-up moves on a
// strictly larger priority only, sift-down prefers the left child.
// One operation is in work at a time; in_ready is high only between them.
// An enqueue sifts up level by level (read the parent, then compare and write)
// and then places its entry. A dequeue loads the root and the last entry, sifts
// down level by level (read both children, then compare and write) and places
// the moving entry. Full or empty cases go straight to the result.
// The result sits in an output register: while the receiver stalls, the next
// operation is still accepted and worked, and only its result waits for
// the register to free up.
// Reset clears the entry count and out_valid; the store keeps stale
// data, which never reaches a result since only entries below the count are used.
module binary_max_heap_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic signed [31:0] item_data,
  input  logic signed [31:0] item_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_data,
  output logic [1:0]  status,
  output logic [7:0]  occupancy
);

  hpq_pkg::state_t   state, state_next;
  hpq_pkg::ram_req_t ram_req;
  hpq_pkg::entry_t   rd_a, rd_b;
  hpq_pkg::entry_t   mov;

  logic [hpq_pkg::CNT_W-1:0]  count;
  logic [hpq_pkg::ADDR_W-1:0] pos;
  logic signed [31:0]         res_data;
  logic [hpq_pkg::STAT_W-1:0] res_status;

  logic                       accept;
  logic                       full, empty;
  logic [hpq_pkg::ADDR_W-1:0] parent;
  logic [hpq_pkg::IDX_W-1:0]  l_idx, r_idx, cnt_ext;
  logic                       l_ok, r_ok;
  logic                       up_swap, take_l, take_r, dn_swap;
  logic signed [31:0]         best_prio;
  hpq_pkg::entry_t            child;
  logic [hpq_pkg::ADDR_W-1:0] child_addr;
  logic                       out_free;

  assign accept   = in_valid && in_ready;
  assign full     = (count == hpq_pkg::CNT_W'(hpq_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign out_free = !out_valid || out_ready;

  // Index arithmetic around the current hole
  assign parent  = (pos - hpq_pkg::ADDR_W'(1)) >> 1;
  assign l_idx   = {1'b0, pos, 1'b1};
  assign r_idx   = l_idx + hpq_pkg::IDX_W'(1);
  assign cnt_ext = hpq_pkg::IDX_W'(count);
  assign l_ok    = l_idx < cnt_ext;
  assign r_ok    = r_idx < cnt_ext;

  // Comparators: parent test going up, child selection going down
  assign up_swap   = $signed(mov.prio) > $signed(rd_a.prio);
  assign take_l    = $signed(rd_a.prio) > $signed(mov.prio);
  assign best_prio = take_l ? rd_a.prio : mov.prio;
  assign take_r    = r_ok && ($signed(rd_b.prio) > $signed(best_prio));
  assign dn_swap   = take_l || take_r;
  assign child     = take_r ? rd_b : rd_a;
  assign child_addr = take_r ? hpq_pkg::ADDR_W'(r_idx) : hpq_pkg::ADDR_W'(l_idx);

  hpq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hpq_pkg::S_IDLE: begin
        if (accept) begin
          if (mode == hpq_pkg::MODE_ENQ) begin
            if (full)       state_next = hpq_pkg::S_RESP;
            else if (empty) state_next = hpq_pkg::S_PLACE;
            else            state_next = hpq_pkg::S_UP_RD;
          end else begin
            if (empty) state_next = hpq_pkg::S_RESP;
            else       state_next = hpq_pkg::S_DN_LOAD;
          end
        end
      end
      hpq_pkg::S_UP_RD: state_next = hpq_pkg::S_UP_CMP;
      hpq_pkg::S_UP_CMP: begin
        if (up_swap && parent != '0) state_next = hpq_pkg::S_UP_RD;
        else                         state_next = hpq_pkg::S_PLACE;
      end
      hpq_pkg::S_DN_LOAD: begin
        if (empty) state_next = hpq_pkg::S_RESP;
        else       state_next = hpq_pkg::S_DN_RD;
      end
      hpq_pkg::S_DN_RD: begin
        if (l_ok) state_next = hpq_pkg::S_DN_CMP;
        else      state_next = hpq_pkg::S_PLACE;
      end
      hpq_pkg::S_DN_CMP: begin
        if (dn_swap) state_next = hpq_pkg::S_DN_RD;
        else         state_next = hpq_pkg::S_PLACE;
      end
      hpq_pkg::S_PLACE: state_next = hpq_pkg::S_RESP;
      hpq_pkg::S_RESP: begin
        if (out_free) state_next = hpq_pkg::S_IDLE;
      end
      default: state_next = hpq_pkg::S_IDLE;
    endcase
  end

  // Store requests and input ready
  always_comb begin
    in_ready        = 1'b0;
    ram_req.we      = 1'b0;
    ram_req.waddr   = pos;
    ram_req.wdata   = mov;
    ram_req.raddr_a = '0;
    ram_req.raddr_b = '0;
    unique case (state)
      hpq_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        ram_req.raddr_b = hpq_pkg::ADDR_W'(count - hpq_pkg::CNT_W'(1));
      end
      hpq_pkg::S_UP_RD: ram_req.raddr_a = parent;
      hpq_pkg::S_UP_CMP: begin
        ram_req.we    = up_swap;
        ram_req.wdata = rd_a;
      end
      hpq_pkg::S_DN_RD: begin
        ram_req.raddr_a = hpq_pkg::ADDR_W'(l_idx);
        ram_req.raddr_b = hpq_pkg::ADDR_W'(r_idx);
      end
      hpq_pkg::S_DN_CMP: begin
        ram_req.we    = dn_swap;
        ram_req.wdata = child;
      end
      hpq_pkg::S_PLACE: ram_req.we = 1'b1;
      hpq_pkg::S_DN_LOAD, hpq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (mode == hpq_pkg::MODE_ENQ && !full) begin
          count <= count + hpq_pkg::CNT_W'(1);
        end else if (mode == hpq_pkg::MODE_DEQ && !empty) begin
          count <= count - hpq_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Hole position, moving entry and pending result
  always_ff @(posedge clk) begin
    unique case (state)
      hpq_pkg::S_IDLE: begin
        if (accept) begin
          res_data <= '0;
          pos      <= hpq_pkg::ADDR_W'(count);
          mov.data <= item_data;
          mov.prio <= item_priority;
          if (mode == hpq_pkg::MODE_ENQ) begin
            res_status <= full ? hpq_pkg::ST_FULL : hpq_pkg::ST_ENQUEUED;
          end else begin
            res_status <= empty ? hpq_pkg::ST_EMPTY : hpq_pkg::ST_DEQUEUED;
          end
        end
      end
      hpq_pkg::S_UP_CMP: begin
        if (up_swap) pos <= parent;
      end
      hpq_pkg::S_DN_LOAD: begin
        res_data <= rd_a.data;
        mov      <= rd_b;
        pos      <= '0;
      end
      hpq_pkg::S_DN_CMP: begin
        if (dn_swap) pos <= child_addr;
      end
      hpq_pkg::S_UP_RD, hpq_pkg::S_DN_RD, hpq_pkg::S_PLACE, hpq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // Output register: load when the result is done and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hpq_pkg::S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hpq_pkg::S_RESP && out_free) begin
      out_data  <= res_data;
      status    <= res_status;
      occupancy <= hpq_pkg::OCC_W'(count);
    end
  end

  // Count stays within the heap size
  assert property (@(posedge clk) disable iff (rst)
    count <= hpq_pkg::CNT_W'(hpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Store writes stay below the count
  assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (hpq_pkg::CNT_W'(ram_req.waddr) < count))
    else $error("store write beyond last entry");

  // Count moves only on an accepted word
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("entry count changed without an operation");

  // Empty and full results report matching occupancy
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hpq_pkg::ST_EMPTY) |-> occupancy == '0)
    else $error("empty dequeue with nonzero occupancy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hpq_pkg::ST_FULL)
      |-> occupancy == hpq_pkg::OCC_W'(hpq_pkg::CAPACITY))
    else $error("dropped enqueue without full occupancy");

endmodule

### hw/rtl/hpq_ram.sv
// Heap entry store: one write port and two registered read ports.
module hpq_ram (
  input  logic              clk,
  input  hpq_pkg::ram_req_t req,
  output hpq_pkg::entry_t   rdata_a,
  output hpq_pkg::entry_t   rdata_b
);

  hpq_pkg::entry_t mem [hpq_pkg::CAPACITY];

  // Write one entry, read two entries, read data registered
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

### sim/binary_max_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// Testbench for the binary max-heap priority queue: heap predictor, scoreboard and stimulus.
module binary_max_heap_priority_queue_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_WAIT     = 40;
  localparam int REPORT_MAX     = 10;

  typedef logic signed [hpq_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t                      data;
    logic [hpq_pkg::STAT_W-1:0] status;
    logic [hpq_pkg::OCC_W-1:0]  occupancy;
  } result_t;

  // Heap predictor plus the queue of results still owed by the block
  class heap_scoreboard;
    word_t   heap_data [hpq_pkg::CAPACITY];
    word_t   heap_prio [hpq_pkg::CAPACITY];
    int      entries;
    result_t awaited [$];
    int      mismatches;

    function new();
      entries    = 0;
      mismatches = 0;
    endfunction

    function void swap_entries(int a, int b);
      word_t d;
      word_t p;
      d = heap_data[a];
      p = heap_prio[a];
      heap_data[a] = heap_data[b];
      heap_prio[a] = heap_prio[b];
      heap_data[b] = d;
      heap_prio[b] = p;
    endfunction

    // Apply one accepted word to the heap and queue the result it owes
    function void note_request(logic op, word_t data, word_t prio);
      result_t res;
      int pos;
      int parent;
      int best;
      int lchild;
      int rchild;
      res.data = '0;
      if (op == hpq_pkg::MODE_ENQ) begin
        if (entries >= hpq_pkg::CAPACITY) begin
          res.status = hpq_pkg::ST_FULL;
        end else begin
          pos = entries;
          heap_data[pos] = data;
          heap_prio[pos] = prio;
          entries++;
          // sift up on strictly larger priority only
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_prio[pos] > heap_prio[parent]) begin
              swap_entries(pos, parent);
              pos = parent;
            end else begin
              break;
            end
          end
          res.status = hpq_pkg::ST_ENQUEUED;
        end
      end else if (entries == 0) begin
        res.status = hpq_pkg::ST_EMPTY;
      end else begin
        res.data = heap_data[0];
        heap_data[0] = heap_data[entries-1];
        heap_prio[0] = heap_prio[entries-1];
        entries--;
        // sift down, left child wins ties, swap on strictly larger child
        pos = 0;
        forever begin
          best   = pos;
          lchild = 2 * pos + 1;
          rchild = 2 * pos + 2;
          if (lchild < entries && heap_prio[lchild] > heap_prio[best]) best = lchild;
          if (rchild < entries && heap_prio[rchild] > heap_prio[best]) best = rchild;
          if (best == pos) break;
          swap_entries(pos, best);
          pos = best;
        end
        res.status = hpq_pkg::ST_DEQUEUED;
      end
      res.occupancy = entries[hpq_pkg::OCC_W-1:0];
      awaited.push_back(res);
    endfunction

    // Compare one returned word against the oldest owed result
    function void check_result(word_t data, logic [hpq_pkg::STAT_W-1:0] status,
                               logic [hpq_pkg::OCC_W-1:0] occupancy);
      result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result at %0t: out_data %h status %0d occupancy %0d",
                   $time, data, status, occupancy);
        return;
      end
      want = awaited.pop_front();
      if (want.data !== data || want.status !== status || want.occupancy !== occupancy) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch at %0t: out_data %h/%h status %0d/%0d occupancy %0d/%0d (exp/act)",
                   $time, want.data, data, want.status, status, want.occupancy, occupancy);
      end
    endfunction
  endclass

  logic  clk           = 1'b0;
  logic  rst           = 1'b1;
  logic  in_valid      = 1'b0;
  logic  mode          = hpq_pkg::MODE_ENQ;
  word_t item_data     = '0;
  word_t item_priority = '0;
  logic  out_ready     = 1'b0;
  logic  in_ready;
  logic  out_valid;
  word_t out_data;
  logic [hpq_pkg::STAT_W-1:0] status;
  logic [hpq_pkg::OCC_W-1:0]  occupancy;

  heap_scoreboard board = new();

  bit valid_up      = 1'b0;
  bit long_hold_req = 1'b0;
  int burst_left    = 1;
  int idle_cycles   = 0;

  binary_max_heap_priority_queue uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .status        (status),
    .occupancy     (occupancy)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word, hold it until accepted, then maybe open a gap
  task automatic offer_word(logic op, word_t data, word_t prio);
    int gap;
    in_valid      <= 1'b1;
    mode          <= op;
    item_data     <= data;
    item_priority <= prio;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, data, prio);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic pause_until_drained();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      @(posedge clk);
    end
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // Priority shapes: full range, a narrow band full of ties, or the extremes
  function automatic word_t pick_prio(int shape);
    case (shape)
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 7)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFFFFFF;
          1:       return 32'sh80000000;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Random mix of enqueues and dequeues; shape below zero picks one per word
  task automatic mixed_run(int count, int enq_pct, int shape_sel);
    logic op;
    int shape;
    repeat (count) begin
      op    = ($urandom_range(1, 100) <= enq_pct) ? hpq_pkg::MODE_ENQ : hpq_pkg::MODE_DEQ;
      shape = (shape_sel < 0) ? $urandom_range(0, 2) : shape_sel;
      offer_word(op, word_t'($urandom), pick_prio(shape));
    end
  endtask

  // Stimulus
  initial begin
    int fill_count;
    int drain_count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dequeue, field extremes, ties, drain past empty
    offer_word(hpq_pkg::MODE_DEQ, 32'sh12345678, 32'sh0);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh7FFFFFFF, 32'sh80000000);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh80000000, 32'sh7FFFFFFF);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh0, 32'sh0);
    offer_word(hpq_pkg::MODE_ENQ, '1, '1);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh00000011, 32'sh5);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh00000022, 32'sh5);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh00000033, 32'sh5);
    offer_word(hpq_pkg::MODE_ENQ, 32'shA5A5A5A5, 32'sh5);
    offer_word(hpq_pkg::MODE_ENQ, 32'sh5A5A5A5A, 32'sh80000000);
    repeat (10) offer_word(hpq_pkg::MODE_DEQ, word_t'($urandom), word_t'($urandom));
    offer_word(hpq_pkg::MODE_ENQ, 32'sh00000044, 32'sh7FFFFFFF);
    offer_word(hpq_pkg::MODE_DEQ, '1, '1);
    pause_until_drained();

    // random, growing
    mixed_run(120, 65, -1);

    // fill past capacity while the receiver holds off
    long_hold_req = 1'b1;
    fill_count = hpq_pkg::CAPACITY - board.entries + 4;
    repeat (fill_count)
      offer_word(hpq_pkg::MODE_ENQ, word_t'($urandom), pick_prio($urandom_range(0, 2)));

    // drain past empty
    drain_count = board.entries + 3;
    repeat (drain_count) offer_word(hpq_pkg::MODE_DEQ, word_t'($urandom), word_t'($urandom));
    pause_until_drained();

    // random, tie-heavy then shrinking
    mixed_run(110, 55, 1);
    mixed_run(110, 40, -1);

    pause_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: stall styles that change from phase to phase, plus one long hold
  initial begin
    int style;
    int phase_left;
    style      = 0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          style      = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= ((phase_left % 8) >= 3);
        endcase
      end
    end
  end

  // Check every returned word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(out_data, status, occupancy);
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
